// ----- hw/rtl/rtzm_pkg.sv -----
// ----------------------------------------------------------------------------
// rtzm_pkg
// Shared types, constants and helpers for the rotozoom texel address generator.
// ----------------------------------------------------------------------------
package rtzm_pkg;

   // default depth of the texture store, as address bits
   localparam int STORE_ADDR_BITS_DEF = 17;

   // 6.12 fixed-point coordinate width
   localparam int COORD_W    = 18;
   localparam int SLICE_W    = 5;
   localparam int TEXEL_W    = 8;
   localparam int CMD_W      = 3;
   localparam int POS_W      = 32;
   // width of the masked pixel address before the slice offset is added
   localparam int PIX_W      = 17;
   localparam int SLICE_SHIFT = 6;

   localparam logic [PIX_W-1:0] PIXEL_MASK = 17'h1f83f;

   // item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_TEXEL = 3'd0,
      CMD_FRAME_START = 3'd1,
      CMD_LINE_START  = 3'd2,
      CMD_PIXEL       = 3'd3,
      CMD_LINE_END    = 3'd4
   } cmd_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CFG_START_X = 2'd0,
      CFG_START_Y = 2'd1,
      CFG_STEP_X  = 2'd2,
      CFG_STEP_Y  = 2'd3
   } cfg_index_type;

   // packed position: x fraction on top, y integer and upper y fraction in the
   // middle, x integer at the bottom; bits 17 to 19 stay zero
   function automatic logic [POS_W-1:0] pack_xy(input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy);
      pack_xy = {cx[11:0], 3'b000, cy[17:7], cx[17:12]};
   endfunction

endpackage

// ----- hw/rtl/rtzm_texture_store.sv -----
// ----------------------------------------------------------------------------
// rtzm_texture_store
// Single-clock byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rtzm_texture_store #(
   parameter int ADDR_BITS = rtzm_pkg::STORE_ADDR_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_BITS-1:0]        wr_addr,
   input  logic [rtzm_pkg::TEXEL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_BITS-1:0]        rd_addr,
   output logic [rtzm_pkg::TEXEL_W-1:0] rd_data
);
   import rtzm_pkg::*;

   logic [TEXEL_W-1:0] mem [2**ADDR_BITS];
   logic [TEXEL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rotozoom_texel_address_generator_top.sv -----
// ----------------------------------------------------------------------------
// rotozoom_texel_address_generator_top
// Rotozoom scanline texel generator with an on-chip texture store.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_tready is high. Write-texel items fill
// the texture store; frame start, line start and line end items update the
// walking state; each pixel item adds the packed step to the position, forms
// the store address and returns the texel and its address through the read
// stage and the output register. The rate is set by the single read port of
// the texture store and the 32-bit position add. A stalled result holds one
// pixel in the read stage and one in the output register before req_tready
// drops. The store has no reset: read only texels already written.
module rotozoom_texel_address_generator_top #(
   parameter int STORE_ADDR_BITS = rtzm_pkg::STORE_ADDR_BITS_DEF,
   localparam int REQ_DATA_W = ((STORE_ADDR_BITS + rtzm_pkg::TEXEL_W
                                 + rtzm_pkg::SLICE_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((STORE_ADDR_BITS + rtzm_pkg::TEXEL_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [rtzm_pkg::COORD_W-1:0]  csr_wdata,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: write_address, write_data, line_texture (lowest bit up)
   input  logic [REQ_DATA_W-1:0]         req_tdata,
   // tuser: command
   input  logic [rtzm_pkg::CMD_W-1:0]    req_tuser,
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: texel, texel_address (lowest bit up)
   output logic [RSP_DATA_W-1:0]         rsp_tdata
);
   import rtzm_pkg::*;

   localparam int WD_LO = STORE_ADDR_BITS;
   localparam int LT_LO = STORE_ADDR_BITS + TEXEL_W;

   // configuration registers
   logic [COORD_W-1:0] start_x_ff, start_y_ff, step_x_ff, step_y_ff;

   // walking state
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               carry_ff, carry_in;
   logic [COORD_W-1:0] line_x_ff, line_x_in, line_y_ff, line_y_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;

   // read stage and output register
   logic                       s1_valid_ff, s1_valid_in;
   logic [STORE_ADDR_BITS-1:0] s1_addr_ff, s1_addr_in;
   logic                       out_valid_ff, out_valid_in;
   logic [STORE_ADDR_BITS-1:0] out_addr_ff, out_addr_in;
   logic [TEXEL_W-1:0]         out_texel_ff, out_texel_in;

   logic                       req_accept, s1_advance;
   cmd_type                    cmd;
   logic [STORE_ADDR_BITS-1:0] wr_addr;
   logic [TEXEL_W-1:0]         wr_data;
   logic [SLICE_W-1:0]         line_texture;
   logic [POS_W:0]             pix_sum;
   logic [PIX_W-1:0]           pix_addr;
   logic [STORE_ADDR_BITS-1:0] rd_addr;
   logic [TEXEL_W-1:0]         rd_data;
   logic                       is_pixel, is_write;
   logic [COORD_W-1:0]         next_line_x, next_line_y;

   // field unpacking
   assign cmd          = cmd_type'(req_tuser);
   assign wr_addr      = req_tdata[STORE_ADDR_BITS-1:0];
   assign wr_data      = req_tdata[WD_LO +: TEXEL_W];
   assign line_texture = req_tdata[LT_LO +: SLICE_W];

   // handshake: the read stage empties when the output register can take it
   assign s1_advance = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign is_pixel   = req_accept && (cmd == CMD_PIXEL);
   assign is_write   = req_accept && (cmd == CMD_WRITE_TEXEL);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         step_x_ff  <= COORD_W'(4096);
         step_y_ff  <= '0;
      end else if (csr_we) begin
         unique case (cfg_index_type'(csr_index))
            CFG_START_X: start_x_ff <= csr_wdata;
            CFG_START_Y: start_y_ff <= csr_wdata;
            CFG_STEP_X:  step_x_ff  <= csr_wdata;
            CFG_STEP_Y:  step_y_ff  <= csr_wdata;
            default:     start_x_ff <= start_x_ff;
         endcase
      end
   end

   // pixel step and store address
   assign pix_sum  = {1'b0, pos_ff} + {1'b0, pack_xy(step_x_ff, step_y_ff)}
                   + {{POS_W{1'b0}}, carry_ff};
   assign pix_addr = (pix_sum[PIX_W-1:0] & PIXEL_MASK)
                   + {{(PIX_W-SLICE_W-SLICE_SHIFT){1'b0}}, slice_ff, {SLICE_SHIFT{1'b0}}};
   assign rd_addr  = STORE_ADDR_BITS'(pix_addr);

   // line end walk
   assign next_line_x = line_x_ff + step_y_ff;
   assign next_line_y = line_y_ff - step_x_ff;

   // walking state update per command
   always_comb begin
      pos_in    = pos_ff;
      carry_in  = carry_ff;
      line_x_in = line_x_ff;
      line_y_in = line_y_ff;
      slice_in  = slice_ff;
      if (req_accept) begin
         case (cmd)
            CMD_FRAME_START: begin
               line_x_in = start_x_ff;
               line_y_in = start_y_ff;
               pos_in    = pack_xy(start_x_ff, start_y_ff);
               carry_in  = 1'b0;
            end
            CMD_LINE_START: begin
               slice_in = line_texture;
               carry_in = 1'b0;
            end
            CMD_PIXEL: begin
               pos_in   = pix_sum[POS_W-1:0];
               carry_in = pix_sum[POS_W];
            end
            CMD_LINE_END: begin
               line_x_in = next_line_x;
               line_y_in = next_line_y;
               pos_in    = pack_xy(next_line_x, next_line_y);
            end
            default: pos_in = pos_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         carry_ff  <= 1'b0;
         line_x_ff <= '0;
         line_y_ff <= '0;
         slice_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         carry_ff  <= carry_in;
         line_x_ff <= line_x_in;
         line_y_ff <= line_y_in;
         slice_ff  <= slice_in;
      end
   end

   // texture store
   rtzm_texture_store #(
      .ADDR_BITS (STORE_ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (is_write),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (is_pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read stage and output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_addr_in   = s1_addr_ff;
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_texel_in = out_texel_ff;
      if (s1_advance) begin
         out_valid_in = s1_valid_ff;
         out_addr_in  = s1_addr_ff;
         out_texel_in = rd_data;
         s1_valid_in  = 1'b0;
      end
      if (is_pixel) begin
         s1_valid_in = 1'b1;
         s1_addr_in  = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= s1_addr_in;
      out_addr_ff  <= out_addr_in;
      out_texel_ff <= out_texel_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_addr_ff, out_texel_ff});

   // checks
   a_stall_holds_read_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("read stage lost its pixel while stalled");

   a_pixel_enters_read_stage: assert property (@(posedge clock) disable iff (reset)
      is_pixel |=> s1_valid_ff && (s1_addr_ff == $past(rd_addr)))
      else $error("accepted pixel missing from read stage");

   a_not_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request side stalled with room in the pipeline");

   a_frame_start_clears_carry: assert property (@(posedge clock) disable iff (reset)
      req_accept && (cmd == CMD_FRAME_START) |=> !carry_ff)
      else $error("carry survived frame start");

   a_reset_empties_pipeline: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
